// ===== sv/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types and code point constants for the UTF-8 comment character
// counter.
// ----------------------------------------------------------------------------
package ucc_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned WIN_D    = 3;
  localparam int unsigned SEQ_D    = 4;
  localparam int unsigned OUT_W    = 32;

  localparam logic [CP_W-1:0] CP_REPL      = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_IDEO_SP   = 21'h003000;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_MIN2      = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3      = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4      = 21'h010000;
  localparam logic [CP_W-1:0] CJK_A_LO     = 21'h004E00;
  localparam logic [CP_W-1:0] CJK_A_HI     = 21'h009FFF;
  localparam logic [CP_W-1:0] CJK_B_LO     = 21'h003400;
  localparam logic [CP_W-1:0] CJK_B_HI     = 21'h004DBF;
  localparam logic [CP_W-1:0] CJK_C_LO     = 21'h020000;
  localparam logic [CP_W-1:0] CJK_C_HI     = 21'h02A6DF;
  localparam logic [CP_W-1:0] CJK_D_LO     = 21'h02A700;
  localparam logic [CP_W-1:0] CJK_D_HI     = 21'h02CEAF;
  localparam logic [CP_W-1:0] CJK_E_LO     = 21'h00F900;
  localparam logic [CP_W-1:0] CJK_E_HI     = 21'h00FAFF;

  typedef logic [SEQ_D-1:0][7:0] seq_t;

  typedef struct packed {
    logic code;
    logic comment;
    logic cjk;
  } hit_t;

endpackage

// ===== sv/ucc_resolve.sv =====
// ----------------------------------------------------------------------------
// ucc_resolve
// Resolves one byte position: strict UTF-8 decode, continuation skipping
// and whitespace / comment / CJK classification.
// ----------------------------------------------------------------------------
module ucc_resolve (
  input  logic                active_i,
  input  logic [1:0]          skip_i,
  input  ucc_pkg::seq_t       bytes_i,
  input  logic [2:0]          avail_i,
  input  logic                comment_i,
  output logic [1:0]          skip_o,
  output ucc_pkg::hit_t       hit_o
);

  logic                      c1, c2, c3;
  logic [10:0]               v2;
  logic [15:0]               v3;
  logic [ucc_pkg::CP_W-1:0]  v4;
  logic [ucc_pkg::CP_W-1:0]  cp;
  logic [1:0]                dec_skip;
  logic                      white;
  logic                      ideo;

  assign c1 = (avail_i > 3'd1) && (bytes_i[1][7:6] == 2'b10);
  assign c2 = (avail_i > 3'd2) && (bytes_i[2][7:6] == 2'b10);
  assign c3 = (avail_i > 3'd3) && (bytes_i[3][7:6] == 2'b10);
  assign v2 = {bytes_i[0][4:0], bytes_i[1][5:0]};
  assign v3 = {bytes_i[0][3:0], bytes_i[1][5:0], bytes_i[2][5:0]};
  assign v4 = {bytes_i[0][2:0], bytes_i[1][5:0], bytes_i[2][5:0], bytes_i[3][5:0]};

  always_comb begin
    cp       = ucc_pkg::CP_REPL;
    dec_skip = 2'd0;
    if (!bytes_i[0][7]) begin
      cp = ucc_pkg::CP_W'(bytes_i[0]);
    end else if (bytes_i[0][7:5] == 3'b110) begin
      if (c1 && (ucc_pkg::CP_W'(v2) >= ucc_pkg::CP_MIN2)) begin
        cp       = ucc_pkg::CP_W'(v2);
        dec_skip = 2'd1;
      end
    end else if (bytes_i[0][7:4] == 4'b1110) begin
      if (c1 && c2 && (ucc_pkg::CP_W'(v3) >= ucc_pkg::CP_MIN3) &&
          !((ucc_pkg::CP_W'(v3) >= ucc_pkg::CP_SURR_LO) &&
            (ucc_pkg::CP_W'(v3) <= ucc_pkg::CP_SURR_HI))) begin
        cp       = ucc_pkg::CP_W'(v3);
        dec_skip = 2'd2;
      end
    end else if (bytes_i[0][7:3] == 5'b11110) begin
      if (c1 && c2 && c3 && (v4 >= ucc_pkg::CP_MIN4) && (v4 <= ucc_pkg::CP_MAX)) begin
        cp       = v4;
        dec_skip = 2'd3;
      end
    end
  end

  assign white = (cp == 21'h20) || (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D) ||
                 (cp == 21'h0B) || (cp == 21'h0C) || (cp == ucc_pkg::CP_IDEO_SP);

  assign ideo = ((cp >= ucc_pkg::CJK_A_LO) && (cp <= ucc_pkg::CJK_A_HI)) ||
                ((cp >= ucc_pkg::CJK_B_LO) && (cp <= ucc_pkg::CJK_B_HI)) ||
                ((cp >= ucc_pkg::CJK_C_LO) && (cp <= ucc_pkg::CJK_C_HI)) ||
                ((cp >= ucc_pkg::CJK_D_LO) && (cp <= ucc_pkg::CJK_D_HI)) ||
                ((cp >= ucc_pkg::CJK_E_LO) && (cp <= ucc_pkg::CJK_E_HI));

  always_comb begin
    skip_o = skip_i;
    hit_o  = '0;
    if (active_i) begin
      if (skip_i != 2'd0) begin
        skip_o = skip_i - 2'd1;
      end else begin
        skip_o = dec_skip;
        if (!white) begin
          hit_o.code    = !comment_i;
          hit_o.comment = comment_i;
          hit_o.cjk     = comment_i && ideo;
        end
      end
    end
  end

endmodule

// ===== sv/ucc_accum.sv =====
// ----------------------------------------------------------------------------
// ucc_accum
// Saturating running total that takes an increment of up to seven per request.
// ----------------------------------------------------------------------------
module ucc_accum #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  clear_i,
  input  logic [2:0]            inc_i,
  output logic [CountWidth-1:0] sum_o
);

  logic [CountWidth-1:0] total_q, total_d;
  logic [CountWidth:0]   sum_ext;

  assign sum_ext = {1'b0, total_q} + (CountWidth + 1)'(inc_i);
  assign sum_o   = sum_ext[CountWidth] ? '1 : sum_ext[CountWidth-1:0];
  assign total_d = clear_i ? '0 : sum_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en_i) begin
      total_q <= total_d;
    end
  end

endmodule

// ===== sv/utf8_comment_char_counter.sv =====
// ----------------------------------------------------------------------------
// utf8_comment_char_counter
// Counts non-whitespace UTF-8 characters of a byte stream as code, comment
// and comment CJK, and emits the three saturating totals at the last byte.
//
//   channel  | dir | tdata                               | side bands
//   ---------+-----+-------------------------------------+------------------
//   s_axis   | in  | [7:0] text_byte                     | tuser comment_flag,
//            |     |                                     | tlast last
//   m_axis   | out | [31:0] code_chars, [63:32] comment_ | none
//            |     | chars, [95:64] comment_cjk_chars    |
//
// One byte per cycle sustained while no last byte stalls; input register, then output register.
// The input register feeds a four-position resolve chain and the totals.
// A last byte stalls only while a previous result waits in the output register.
// Reset clears the window fill count, skip count and totals; no clearing pass.
// ----------------------------------------------------------------------------
module utf8_comment_char_counter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] comment_flag
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [31:0] code, [63:32] comment, [95:64] cjk
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_flag_q;
  logic                 in_last_q;
  logic                 advance;

  logic [7:0]           win_byte_q [ucc_pkg::WIN_D];
  logic                 win_flag_q [ucc_pkg::WIN_D];
  logic [1:0]           fill_q, fill_d;
  logic [1:0]           skip_q, skip_d;

  logic [7:0]           s_byte [ucc_pkg::SEQ_D];
  logic                 s_flag [ucc_pkg::SEQ_D];
  logic [2:0]           n_seq;

  logic [1:0]           chain_skip [ucc_pkg::SEQ_D+1];
  ucc_pkg::hit_t        hit [ucc_pkg::SEQ_D];
  logic [2:0]           inc_code, inc_comment, inc_cjk;

  logic [COUNT_WIDTH-1:0] sum_code, sum_comment, sum_cjk;

  logic                 out_valid_q;
  logic [95:0]          out_data_q;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_flag_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    for (int k = 0; k < ucc_pkg::SEQ_D; k++) begin
      s_byte[k] = '0;
      s_flag[k] = 1'b0;
    end
    for (int k = 0; k < ucc_pkg::WIN_D; k++) begin
      if (2'(k) < fill_q) begin
        s_byte[k] = win_byte_q[k];
        s_flag[k] = win_flag_q[k];
      end else if (2'(k) == fill_q) begin
        s_byte[k] = in_byte_q;
        s_flag[k] = in_flag_q;
      end
    end
    if (fill_q == 2'd3) begin
      s_byte[3] = in_byte_q;
      s_flag[3] = in_flag_q;
    end
  end

  assign n_seq         = {1'b0, fill_q} + 3'd1;
  assign chain_skip[0] = skip_q;

  for (genvar k = 0; k < ucc_pkg::SEQ_D; k++) begin : g_pos
    ucc_pkg::seq_t unit_bytes;
    logic          unit_active;
    logic [2:0]    unit_avail;

    always_comb begin
      unit_bytes = '0;
      for (int j = 0; j < ucc_pkg::SEQ_D - k; j++) begin
        unit_bytes[j] = s_byte[k + j];
      end
    end

    assign unit_avail  = n_seq - 3'(k);
    assign unit_active = (3'(k) < n_seq) && (in_last_q || ((k == 0) && (fill_q == 2'd3)));

    ucc_resolve u_resolve (
      .active_i  (unit_active),
      .skip_i    (chain_skip[k]),
      .bytes_i   (unit_bytes),
      .avail_i   (unit_avail),
      .comment_i (s_flag[k]),
      .skip_o    (chain_skip[k+1]),
      .hit_o     (hit[k])
    );
  end

  always_comb begin
    inc_code    = '0;
    inc_comment = '0;
    inc_cjk     = '0;
    for (int k = 0; k < ucc_pkg::SEQ_D; k++) begin
      inc_code    = inc_code    + 3'(hit[k].code);
      inc_comment = inc_comment + 3'(hit[k].comment);
      inc_cjk     = inc_cjk     + 3'(hit[k].cjk);
    end
  end

  assign skip_d = in_last_q ? 2'd0 : chain_skip[ucc_pkg::SEQ_D];
  assign fill_d = in_last_q ? 2'd0 : ((fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      skip_q <= '0;
    end else if (advance) begin
      fill_q <= fill_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !in_last_q) begin
      if (fill_q == 2'd3) begin
        win_byte_q[0] <= win_byte_q[1];
        win_byte_q[1] <= win_byte_q[2];
        win_byte_q[2] <= in_byte_q;
        win_flag_q[0] <= win_flag_q[1];
        win_flag_q[1] <= win_flag_q[2];
        win_flag_q[2] <= in_flag_q;
      end else begin
        win_byte_q[fill_q] <= in_byte_q;
        win_flag_q[fill_q] <= in_flag_q;
      end
    end
  end

  ucc_accum #(.CountWidth(COUNT_WIDTH)) u_code (
    .clk_i, .rst_ni, .en_i(advance), .clear_i(in_last_q), .inc_i(inc_code), .sum_o(sum_code)
  );

  ucc_accum #(.CountWidth(COUNT_WIDTH)) u_comment (
    .clk_i, .rst_ni, .en_i(advance), .clear_i(in_last_q), .inc_i(inc_comment),
    .sum_o(sum_comment)
  );

  ucc_accum #(.CountWidth(COUNT_WIDTH)) u_cjk (
    .clk_i, .rst_ni, .en_i(advance), .clear_i(in_last_q), .inc_i(inc_cjk), .sum_o(sum_cjk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q[31:0]  <= ucc_pkg::OUT_W'(64'(sum_code));
      out_data_q[63:32] <= ucc_pkg::OUT_W'(64'(sum_comment));
      out_data_q[95:64] <= ucc_pkg::OUT_W'(64'(sum_cjk));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_skip_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != 2'd0) |-> (fill_q == 2'd3))
    else $error("skip pending without a full window");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (out_valid_q && (fill_q == 2'd0) && (skip_q == 2'd0)))
    else $error("last byte did not emit a result and clear state");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a waiting result");

  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(advance && in_last_q)) |=> !out_valid_q)
    else $error("result appeared without a last byte");

endmodule
